>>> design/trap_interrupt_entry_arbiter_core_assert.svh
// Assertion macros for the trap and interrupt entry arbiter.
// Needs i_clk and i_rst_n in the scope in which a macro is used.
`ifndef TRAP_INTERRUPT_ENTRY_ARBITER_CORE_ASSERT_SVH
`define TRAP_INTERRUPT_ENTRY_ARBITER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TIE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("trap arbiter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TIE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("trap arbiter: next-cycle check failed");

`endif

>>> design/tie_pkg.sv
// Package for the trap and interrupt entry arbiter: request and bus
// operation codes, register indexes, reset values and field widths. No dependencies.
package tie_pkg;

    // Field widths fixed by the interface
    localparam int REQ_W  = 2;
    localparam int LINE_W = 4;
    localparam int WORD_W = 16;
    localparam int PRIO_W = 3;
    localparam int SRC_W  = 3;
    localparam int KIND_W = 3;
    localparam int TS_W   = 5;

    // Configuration port
    localparam int CFG_IDX_W = 4;
    localparam int NUM_REGS  = 8;

    localparam int NUM_LINES_DEF = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_RAISE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POST  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CHECK = 2'd3;

    // Bus operation codes
    localparam logic [KIND_W-1:0] OP_NONE    = 3'd0;
    localparam logic [KIND_W-1:0] OP_RD_PC   = 3'd1;
    localparam logic [KIND_W-1:0] OP_WR      = 3'd2;
    localparam logic [KIND_W-1:0] OP_RD_PSW  = 3'd3;
    localparam logic [KIND_W-1:0] OP_RESTART = 3'd4;

    // Register indexes
    localparam int CFG_RESTART = 0;
    localparam int CFG_HALTPSW = 1;
    localparam int CFG_BUS     = 2;
    localparam int CFG_RSVD    = 3;
    localparam int CFG_BPT     = 4;
    localparam int CFG_IOT     = 5;
    localparam int CFG_EMT     = 6;
    localparam int CFG_TRAP    = 7;

    // Internal source codes
    localparam logic [SRC_W-1:0] SRC_HALT = 3'd0;
    localparam logic [SRC_W-1:0] SRC_BUS  = 3'd1;
    localparam logic [SRC_W-1:0] SRC_RSVD = 3'd2;
    localparam logic [SRC_W-1:0] SRC_BPT  = 3'd3;
    localparam logic [SRC_W-1:0] SRC_IOT  = 3'd4;
    localparam logic [SRC_W-1:0] SRC_EMT  = 3'd5;
    localparam logic [SRC_W-1:0] SRC_TRAP = 3'd6;
    localparam logic [SRC_W-1:0] SRC_TBIT = 3'd7;

    // Offset added to a line number to form its taken-source code
    localparam logic [TS_W-1:0] LINE_SRC_BASE = 5'd8;

    // PSW priority field position
    localparam int PSW_PRIO_LSB = 5;

    typedef logic [WORD_W-1:0] t_word;

    // Reset values of the configuration registers
    function automatic t_word cfg_reset(input int idx);
        t_word v;
        case (idx)
            CFG_RESTART: v = 16'hF404;
            CFG_HALTPSW: v = 16'h00E0;
            CFG_BUS:     v = 16'd4;
            CFG_RSVD:    v = 16'd8;
            CFG_BPT:     v = 16'd12;
            CFG_IOT:     v = 16'd16;
            CFG_EMT:     v = 16'd24;
            CFG_TRAP:    v = 16'd28;
            default:     v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> design/trap_interrupt_entry_arbiter_core.sv
// Trap and interrupt entry arbiter: pending flags, service check and entry bus run.
// Depends on tie_pkg and on trap_interrupt_entry_arbiter_core_assert.svh.
//
//  Channel   | Handshake                 | Payload
//  ----------+---------------------------+--------------------------------------------
//  request   | i_start, o_busy           | i_req_type, i_line, i_vector_address, ...
//  result    | o_strobe (one cycle)      | o_op_kind, o_address, o_write_data, ...
//  config    | i_cfg_we                  | i_cfg_index, i_cfg_wdata
//
// A request is taken when i_start is high and o_busy low, registered, and decided in
// the following cycle. After a raise, clear or post, o_busy falls once that request is decided.
// A service check that finds a winner then runs the entry sequence from a step counter,
// one bus operation a cycle: PSW and PC pushes, with vector reads or a halt restart.
// Reset is synchronous and active low; it clears all pending flags and restores the
// registers. The result receiver cannot stall, so results leave one per cycle.
`include "trap_interrupt_entry_arbiter_core_assert.svh"

module trap_interrupt_entry_arbiter_core
    import tie_pkg::*;
#(
    parameter int NUM_LINES = NUM_LINES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [LINE_W-1:0]    i_line,
    input  logic [WORD_W-1:0]    i_vector_address,
    input  logic [PRIO_W-1:0]    i_source_priority,
    input  logic [SRC_W-1:0]     i_trap_source,
    input  logic [WORD_W-1:0]    i_cpu_psw,
    input  logic [WORD_W-1:0]    i_cpu_pc,
    input  logic [WORD_W-1:0]    i_stack_pointer,
    // result channel
    output logic                 o_strobe,
    output logic [KIND_W-1:0]    o_op_kind,
    output logic [WORD_W-1:0]    o_address,
    output logic [WORD_W-1:0]    o_write_data,
    output logic [TS_W-1:0]      o_taken_source,
    output logic                 o_last_op,
    // configuration port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_wdata
);

    localparam int LIX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

    // Configuration registers
    t_word r_cfg [NUM_REGS];

    // Pending flags and latched line data
    logic [NUM_REGS-1:0]  r_int_pend;
    logic [NUM_LINES-1:0] r_line_pend;
    t_word                r_line_vec  [NUM_LINES];
    logic [PRIO_W-1:0]    r_line_prio [NUM_LINES];

    // Input register
    logic                 r_stage_v;
    logic [REQ_W-1:0]     r_req;
    logic [LINE_W-1:0]    r_line;
    t_word                r_vec_in;
    logic [PRIO_W-1:0]    r_prio_in;
    logic [SRC_W-1:0]     r_src_in;
    t_word                r_psw;
    t_word                r_pc;
    t_word                r_sp;

    // Entry run
    logic                 r_run;
    logic                 r_halt;
    logic [1:0]           r_step;
    t_word                r_run_vec;
    logic [TS_W-1:0]      r_run_src;

    // Result register
    logic                 r_out_v;
    logic [KIND_W-1:0]    r_out_kind;
    t_word                r_out_addr;
    t_word                r_out_data;
    logic [TS_W-1:0]      r_out_src;
    logic                 r_out_last;

    logic                 accept;
    logic [5:0]           line_wide;
    logic [LIX_W-1:0]     line_idx;
    logic                 line_ok;
    logic [PRIO_W-1:0]    cur_prio;
    logic [NUM_LINES-1:0] line_elig;
    logic                 line_found;
    logic [LIX_W-1:0]     win_line;
    logic                 int_found;
    logic [SRC_W-1:0]     win_int;
    t_word                int_vec;

    logic [KIND_W-1:0]    n_kind;
    t_word                n_addr;
    t_word                n_data;
    logic                 n_last;

    assign accept = i_start && !o_busy;
    assign o_busy = r_stage_v || r_run;

    // Line number of the registered request, checked against the line count
    assign line_wide = 6'(r_line);
    assign line_idx  = line_wide[LIX_W-1:0];
    assign line_ok   = 32'(r_line) < NUM_LINES;
    assign cur_prio  = r_psw[PSW_PRIO_LSB +: PRIO_W];

    // Lowest-numbered pending line whose priority exceeds the PSW priority
    always_comb begin
        line_found = 1'b0;
        win_line   = '0;
        for (int i = NUM_LINES - 1; i >= 0; i--) begin
            line_elig[i] = r_line_pend[i] && (r_line_prio[i] > cur_prio);
            if (line_elig[i]) begin
                line_found = 1'b1;
                win_line   = LIX_W'(i);
            end
        end
    end

    // Lowest-numbered pending internal source
    always_comb begin
        int_found = 1'b0;
        win_int   = '0;
        for (int s = NUM_REGS - 1; s >= 0; s--) begin
            if (r_int_pend[s]) begin
                int_found = 1'b1;
                win_int   = SRC_W'(s);
            end
        end
    end

    // Vector of the winning internal source; T-bit shares the breakpoint vector
    always_comb begin
        case (win_int)
            SRC_BUS:  int_vec = r_cfg[CFG_BUS];
            SRC_RSVD: int_vec = r_cfg[CFG_RSVD];
            SRC_BPT:  int_vec = r_cfg[CFG_BPT];
            SRC_IOT:  int_vec = r_cfg[CFG_IOT];
            SRC_EMT:  int_vec = r_cfg[CFG_EMT];
            SRC_TRAP: int_vec = r_cfg[CFG_TRAP];
            SRC_TBIT: int_vec = r_cfg[CFG_BPT];
            default:  int_vec = '0;
        endcase
    end

    // Configuration writes; indexes beyond the register list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_cfg[k] <= cfg_reset(k);
            end
        end else if (i_cfg_we && (32'(i_cfg_index) < NUM_REGS)) begin
            r_cfg[i_cfg_index[2:0]] <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_v <= 1'b0;
        end else begin
            r_stage_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req     <= i_req_type;
            r_line    <= i_line;
            r_vec_in  <= i_vector_address;
            r_prio_in <= i_source_priority;
            r_src_in  <= i_trap_source;
            r_psw     <= i_cpu_psw;
            r_pc      <= i_cpu_pc;
            r_sp      <= i_stack_pointer;
        end
    end

    // Decision: update pending state and start an entry run on a winner
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_pend  <= '0;
            r_line_pend <= '0;
            r_run       <= 1'b0;
            r_step      <= '0;
        end else if (r_stage_v) begin
            case (r_req)
                REQ_RAISE: begin
                    if (line_ok) begin
                        r_line_pend[line_idx] <= 1'b1;
                    end
                end
                REQ_CLEAR: begin
                    if (line_ok) begin
                        r_line_pend[line_idx] <= 1'b0;
                    end
                end
                REQ_POST: begin
                    r_int_pend[r_src_in] <= 1'b1;
                end
                REQ_CHECK: begin
                    if (int_found) begin
                        r_int_pend[win_int] <= 1'b0;
                        r_run  <= 1'b1;
                        r_step <= '0;
                    end else if (line_found) begin
                        r_line_pend[win_line] <= 1'b0;
                        r_run  <= 1'b1;
                        r_step <= '0;
                    end
                end
                default: begin
                end
            endcase
        end else if (r_run) begin
            r_step <= r_step + 2'd1;
            if (n_last) begin
                r_run <= 1'b0;
            end
        end
    end

    // Latched vector and priority of a raised line, and the run's winner data
    always_ff @(posedge i_clk) begin
        if (r_stage_v && (r_req == REQ_RAISE) && line_ok) begin
            r_line_vec[line_idx]  <= r_vec_in;
            r_line_prio[line_idx] <= r_prio_in;
        end
        if (r_stage_v) begin
            if (int_found) begin
                r_halt    <= (win_int == SRC_HALT);
                r_run_vec <= int_vec;
                r_run_src <= TS_W'(win_int);
            end else begin
                r_halt    <= 1'b0;
                r_run_vec <= r_line_vec[win_line];
                r_run_src <= TS_W'(win_line) + LINE_SRC_BASE;
            end
        end
    end

    // Bus operation for the current step of the run
    always_comb begin
        n_kind = OP_NONE;
        n_addr = '0;
        n_data = '0;
        n_last = 1'b0;
        if (r_halt) begin
            case (r_step)
                2'd0: begin
                    n_kind = OP_WR;
                    n_addr = r_sp - 16'd2;
                    n_data = r_psw;
                end
                2'd1: begin
                    n_kind = OP_WR;
                    n_addr = r_sp - 16'd4;
                    n_data = r_pc;
                end
                default: begin
                    n_kind = OP_RESTART;
                    n_addr = r_cfg[CFG_RESTART];
                    n_data = r_cfg[CFG_HALTPSW];
                    n_last = 1'b1;
                end
            endcase
        end else begin
            case (r_step)
                2'd0: begin
                    n_kind = OP_RD_PC;
                    n_addr = r_run_vec;
                end
                2'd1: begin
                    n_kind = OP_WR;
                    n_addr = r_sp - 16'd2;
                    n_data = r_psw;
                end
                2'd2: begin
                    n_kind = OP_WR;
                    n_addr = r_sp - 16'd4;
                    n_data = r_pc;
                end
                default: begin
                    n_kind = OP_RD_PSW;
                    n_addr = r_run_vec + 16'd2;
                    n_last = 1'b1;
                end
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_run && !r_stage_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_run && !r_stage_v) begin
            r_out_kind <= n_kind;
            r_out_addr <= n_addr;
            r_out_data <= n_data;
            r_out_src  <= r_run_src;
            r_out_last <= n_last;
        end
    end

    assign o_strobe       = r_out_v;
    assign o_op_kind      = r_out_kind;
    assign o_address      = r_out_addr;
    assign o_write_data   = r_out_data;
    assign o_taken_source = r_out_src;
    assign o_last_op      = r_out_last;

    // Assertions
    `TIE_ASSERT_SAME(a_run_excl, r_run, !r_stage_v)
    `TIE_ASSERT_SAME(a_strobe_kind, o_strobe, o_op_kind != OP_NONE)
    `TIE_ASSERT_NEXT(a_last_ends, o_strobe && o_last_op, !o_strobe)
    `TIE_ASSERT_NEXT(a_accept_busy, accept, o_busy)

endmodule
